@@ sv/mss_pkg.sv @@
// Shared types, sizes and constant functions for the MinHash shingle signature unit.
// Used by mss_window, mss_cell and minhash_shingle_signature_unit; no dependencies.
`default_nettype none

package mss_pkg;

    localparam int SHINGLE_LEN = 3;
    localparam int NUM_HASHES  = 64;

    // Count of held bytes, 0 .. SHINGLE_LEN; also selects the power 31^L.
    localparam int CNT_W = $clog2(SHINGLE_LEN + 1);
    // Signature words still to be delivered, 0 .. NUM_HASHES.
    localparam int REM_W = $clog2(NUM_HASHES + 1);

    localparam int HASH_W  = 64;
    localparam int INDEX_W = 6;

    typedef struct packed {
        logic              fold;   // fold value into every running minimum
        logic              last;   // end of text: capture the signature
        logic [CNT_W-1:0]  power;  // shingle length L, hash uses 31^L
        logic [HASH_W-1:0] value;  // window hash W
    } fold_t;

    function automatic logic [HASH_W-1:0] pow31(input int l);
        logic [HASH_W-1:0] p;
        p = 64'd1;
        for (int k = 0; k < l; k++)
        begin
            p = p * 64'd31;
        end
        return p;
    endfunction

    // seed(i) * 31^l modulo 2^64, with seed(i) = 17*i + 31.
    function automatic logic [HASH_W-1:0] seed_power(input int i, input int l);
        logic [HASH_W-1:0] seed;
        seed = 64'(i * 17 + 31);
        return seed * pow31(l);
    endfunction

endpackage

`default_nettype wire

@@ sv/mss_window.sv @@
// Byte window and rolling base-31 hash for the MinHash shingle signature unit.
// Depends on mss_pkg for sizes, the fold_t word and pow31.
`default_nettype none

module mss_window (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [7:0]            text_byte,
    input  wire logic                  has_byte,
    input  wire logic                  end_of_text,
    input  wire logic                  byte_signed,
    output mss_pkg::fold_t             fold_next
);

    localparam logic [mss_pkg::HASH_W-1:0] POW31_K = mss_pkg::pow31(mss_pkg::SHINGLE_LEN);
    localparam logic [mss_pkg::CNT_W-1:0]  CNT_FULL = mss_pkg::CNT_W'(mss_pkg::SHINGLE_LEN);

    logic [7:0] win_reg [0:mss_pkg::SHINGLE_LEN-1];
    logic [7:0] win_next [0:mss_pkg::SHINGLE_LEN-1];

    // The hash is kept as two parts: the bytes taken unsigned, and the weighted
    // sum of their sign bits, so a change of byte_signed between bytes is exact.
    logic [mss_pkg::HASH_W-1:0] u_reg, u_next;
    logic [mss_pkg::HASH_W-1:0] s_reg, s_next;
    logic [mss_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic                       full;
    logic [mss_pkg::HASH_W-1:0] u_shift, s_shift, u_new, s_new, u_drop, s_drop;
    logic [mss_pkg::CNT_W-1:0]  cnt_new;

    always_comb
    begin
        full    = (cnt_reg == CNT_FULL);
        u_shift = (u_reg << 5) - u_reg;
        s_shift = (s_reg << 5) - s_reg;
        u_drop  = full ? ({56'd0, win_reg[0]} * POW31_K) : '0;
        s_drop  = (full && win_reg[0][7]) ? POW31_K : '0;

        if (has_byte)
        begin
            u_new   = u_shift - u_drop + {56'd0, text_byte};
            s_new   = s_shift - s_drop + {63'd0, text_byte[7]};
            cnt_new = full ? cnt_reg : cnt_reg + mss_pkg::CNT_W'(1);
        end
        else
        begin
            u_new   = u_reg;
            s_new   = s_reg;
            cnt_new = cnt_reg;
        end

        fold_next.fold  = (has_byte && cnt_new == CNT_FULL) ||
                          (end_of_text && cnt_new != CNT_FULL);
        fold_next.last  = end_of_text;
        fold_next.power = cnt_new;
        fold_next.value = u_new - (byte_signed ? (s_new << 8) : '0);

        for (int j = 0; j < mss_pkg::SHINGLE_LEN - 1; j++)
        begin
            win_next[j] = win_reg[j + 1];
        end
        win_next[mss_pkg::SHINGLE_LEN-1] = text_byte;

        if (end_of_text)
        begin
            u_next   = '0;
            s_next   = '0;
            cnt_next = '0;
        end
        else
        begin
            u_next   = u_new;
            s_next   = s_new;
            cnt_next = cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_reg   <= '0;
            s_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            u_reg   <= u_next;
            s_reg   <= s_next;
            cnt_reg <= cnt_next;
        end
    end

    // Only bytes already written are ever read, so the window has no reset.
    always_ff @(posedge clk)
    begin
        if (accept && has_byte)
        begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/mss_cell.sv @@
// One cell of the signature row: a running minimum for one hash function and
// one stage of the output shift chain. Depends on mss_pkg for fold_t.
`default_nettype none

module mss_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mss_pkg::fold_t             fold_in,
    input  wire logic [mss_pkg::HASH_W-1:0] offset,
    input  wire logic                       shift_en,
    input  wire logic [mss_pkg::HASH_W-1:0] chain_in,
    output logic      [mss_pkg::HASH_W-1:0] chain_out
);

    logic [mss_pkg::HASH_W-1:0] min_reg, min_next;
    logic [mss_pkg::HASH_W-1:0] out_reg, out_next;
    logic [mss_pkg::HASH_W-1:0] h, folded;

    always_comb
    begin
        h      = offset + fold_in.value;
        folded = (fold_in.fold && h < min_reg) ? h : min_reg;

        // At end of text the final minimum moves into the chain and the
        // minimum starts over for the next text.
        min_next = fold_in.last ? '1 : folded;

        if (fold_in.last)
        begin
            out_next = folded;
        end
        else if (shift_en)
        begin
            out_next = chain_in;
        end
        else
        begin
            out_next = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '1;
        end
        else
        begin
            min_reg <= min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign chain_out = out_reg;

endmodule

`default_nettype wire

@@ sv/minhash_shingle_signature_unit.sv @@
// Top level of the MinHash shingle signature unit: window front end, fold
// stage and the row of mss_cell minima. Depends on mss_pkg, mss_window, mss_cell.
//
//   channel  | handshake               | word
//   ---------+-------------------------+------------------------------------
//   input    | in_valid / in_ready     | text_byte, has_byte, end_of_text
//   output   | out_valid / out_ready   | hash_index, min_value, last_word
//   config   | cfg_wr_en (no wait)     | cfg_wr_data -> byte_signed
//
// One input word per cycle unless stalled. A taken word is registered in the
// fold stage, then folded into all minima; an end of text loads the output
// chain in that same cycle. The NUM_HASHES signature words leave the chain one
// per cycle while out_ready is high. An end-of-text word waits in the fold
// stage until the previous signature has fully drained, and holds off input
// meanwhile. Reset restores all minima to all ones and byte_signed to 1.
`default_nettype none

module minhash_shingle_signature_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  text_byte,
    input  wire logic                        has_byte,
    input  wire logic                        end_of_text,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [mss_pkg::INDEX_W-1:0] hash_index,
    output logic      [mss_pkg::HASH_W-1:0]  min_value,
    output logic                             last_word,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_wr_data
);

    localparam int N = mss_pkg::NUM_HASHES;
    localparam int K = mss_pkg::SHINGLE_LEN;

    logic                        byte_signed_reg;
    logic                        accept;
    logic                        stall;
    logic                        shift_en;
    mss_pkg::fold_t              fold_next;
    mss_pkg::fold_t              s1_reg, s1_next;
    mss_pkg::fold_t              cell_in;
    logic [mss_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [mss_pkg::REM_W-1:0]   word_idx;
    logic [mss_pkg::HASH_W-1:0]  chain [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_signed_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            byte_signed_reg <= cfg_wr_data;
        end
    end

    mss_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .has_byte    (has_byte),
        .end_of_text (end_of_text),
        .byte_signed (byte_signed_reg),
        .fold_next   (fold_next)
    );

    always_comb
    begin
        stall    = s1_reg.last && (rem_reg != '0);
        in_ready = !stall;
        accept   = in_valid && in_ready;
        shift_en = out_valid && out_ready;

        cell_in      = s1_reg;
        cell_in.fold = s1_reg.fold && !stall;
        cell_in.last = s1_reg.last && !stall;

        if (accept)
        begin
            s1_next = fold_next;
        end
        else if (stall)
        begin
            s1_next = s1_reg;
        end
        else
        begin
            s1_next = '0;
        end

        if (cell_in.last)
        begin
            rem_next = mss_pkg::REM_W'(N);
        end
        else if (shift_en)
        begin
            rem_next = rem_reg - mss_pkg::REM_W'(1);
        end
        else
        begin
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            rem_reg <= '0;
        end
        else
        begin
            s1_reg  <= s1_next;
            rem_reg <= rem_next;
        end
    end

    assign chain[N] = '1;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [mss_pkg::HASH_W-1:0] offs [0:K];

        // Each cell sees its own seed times 31^L as a small constant table.
        for (genvar l = 0; l <= K; l++)
        begin : g_offs
            assign offs[l] = mss_pkg::seed_power(i, l);
        end

        mss_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .fold_in   (cell_in),
            .offset    (offs[s1_reg.power]),
            .shift_en  (shift_en),
            .chain_in  (chain[i + 1]),
            .chain_out (chain[i])
        );
    end

    assign word_idx   = mss_pkg::REM_W'(N) - rem_reg;
    assign out_valid  = (rem_reg != '0);
    assign hash_index = mss_pkg::INDEX_W'(word_idx);
    assign min_value  = chain[0];
    assign last_word  = (rem_reg == mss_pkg::REM_W'(1));

endmodule

`default_nettype wire
